### hw/rtl/flvaac_pkg.sv
// ----------------------------------------------------------------------------
// flvaac_pkg
// Shared types and constants for the FLV AAC to ADTS converter.
// ----------------------------------------------------------------------------
package flvaac_pkg;

   localparam logic [3:0]  AAC_FORMAT   = 4'd10;
   localparam logic [12:0] MAX_TAG_LEN  = 13'd8186;
   localparam logic [2:0]  HDR_BYTES    = 3'd7;
   localparam logic [11:0] ADTS_SYNC    = 12'hFFF;
   localparam logic [10:0] BUF_FULLNESS = 11'h7FF;
   localparam logic [12:0] HDR_LEN      = 13'd7;

   localparam logic [7:0] PKT_SEQ_HDR = 8'd0;
   localparam logic [7:0] PKT_RAW     = 8'd1;

   // results produced by one accepted request, handed to the output buffer
   typedef struct packed {
      logic        load;
      logic [2:0]  count;
      logic [55:0] data;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [2:0] count;
   } emit_status_type;

endpackage

### hw/rtl/flv_aac_to_adts_converter.sv
// ----------------------------------------------------------------------------
// flv_aac_to_adts_converter
// Rewraps FLV AAC audio tags as ADTS frames, one byte per cycle while rsp_ does not stall.
// ----------------------------------------------------------------------------
// Input channel req_: one tag byte per request, req_tag_start on the format
// byte together with the tag length. Output channel rsp_: ADTS frame bytes,
// rsp_out_last on the final byte of each frame.
// A raw AAC packet-type byte yields a 7-byte ADTS header; each payload byte
// yields one byte. Results appear in the cycle after the request is taken.
// Throughput: one request per cycle for pass-through bytes while rsp_ does
// not stall; the packet-type byte of a raw frame holds req_stall while the
// output buffer shifts the header out. Sequence-header and non-AAC bytes
// produce nothing and cause no stall of their own.
// A stall on rsp_ holds the current byte and, once the buffer cannot drain
// in that cycle, raises req_stall.
// Synchronous reset clears the tag position, the stored profile, rate
// index and channel configuration, and empties the output buffer.
// ----------------------------------------------------------------------------
module flv_aac_to_adts_converter
   import flvaac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_tag_byte,
   input  logic        req_tag_start,
   input  logic [12:0] req_tag_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last
);

   result_type      result;
   emit_status_type status;
   logic            free;
   logic            accept;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   flvaac_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .tag_byte   (req_tag_byte),
      .tag_start  (req_tag_start),
      .tag_length (req_tag_length),
      .result     (result)
   );

   flvaac_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .rsp_stall    (rsp_stall),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .status       (status)
   );

   // results of an accepted request must show up next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      result.load |=> rsp_valid)
      else $error("loaded results not presented");

   // input must be held off while more than one byte is still buffered
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (status.count > 3'd1) |-> req_stall)
      else $error("request accepted over pending header bytes");

   // last marks only the final buffered byte
   a_last_final: assert property (@(posedge clock) disable iff (reset)
      rsp_out_last |-> (rsp_valid && status.count == 3'd1))
      else $error("last flag on a non-final byte");

   // a waiting byte stays put while the receiver stalls
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)))
      else $error("stalled response changed");

endmodule

### hw/rtl/flvaac_parser.sv
// ----------------------------------------------------------------------------
// flvaac_parser
// Tag parser: tracks the byte position within a tag, keeps the stream
// configuration and builds the ADTS header or the pass-through byte.
// ----------------------------------------------------------------------------
module flvaac_parser
   import flvaac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  tag_byte,
   input  logic        tag_start,
   input  logic [12:0] tag_length,
   output result_type  result
);

   logic [12:0] byte_position_ff, byte_position_in;
   logic [3:0]  sound_format_ff, sound_format_in;
   logic [7:0]  packet_kind_ff, packet_kind_in;
   logic [12:0] payload_length_ff, payload_length_in;
   logic [1:0]  profile_code_ff, profile_code_in;
   logic [3:0]  rate_index_ff, rate_index_in;
   logic [2:0]  channel_code_ff, channel_code_in;

   logic [12:0] len_sat;
   logic [12:0] end_pos;
   logic [12:0] frame_len;
   logic        is_aac;
   logic [55:0] header;

   assign len_sat   = (tag_length > MAX_TAG_LEN) ? MAX_TAG_LEN : tag_length;
   assign end_pos   = payload_length_ff + 13'd1;
   assign frame_len = HDR_LEN + payload_length_ff;
   assign is_aac    = (sound_format_ff == AAC_FORMAT);

   assign header = {ADTS_SYNC, 1'b0, 2'b00, 1'b1, profile_code_ff, rate_index_ff,
                    1'b0, channel_code_ff, 4'b0000, frame_len, BUF_FULLNESS, 2'b00};

   always_comb begin
      byte_position_in  = byte_position_ff;
      sound_format_in   = sound_format_ff;
      packet_kind_in    = packet_kind_ff;
      payload_length_in = payload_length_ff;
      profile_code_in   = profile_code_ff;
      rate_index_in     = rate_index_ff;
      channel_code_in   = channel_code_ff;
      result            = '0;

      if (accept) begin
         if (tag_start) begin
            sound_format_in   = tag_byte[7:4];
            packet_kind_in    = PKT_SEQ_HDR;
            payload_length_in = (len_sat >= 13'd2) ? len_sat - 13'd2 : 13'd0;
            byte_position_in  = (len_sat >= 13'd2) ? 13'd1 : 13'd0;
         end else if (byte_position_ff != 13'd0) begin
            if (byte_position_ff == 13'd1) begin
               packet_kind_in = tag_byte;
               if (is_aac && tag_byte == PKT_RAW) begin
                  result.load  = 1'b1;
                  result.count = HDR_BYTES;
                  result.data  = header;
                  result.last  = (payload_length_ff == 13'd0);
               end
            end else if (is_aac && packet_kind_ff == PKT_SEQ_HDR) begin
               // audio specific config: object type, rate index, channels
               if (byte_position_ff == 13'd2) begin
                  profile_code_in = tag_byte[4:3] - 2'd1;
                  rate_index_in   = {tag_byte[2:0], rate_index_ff[0]};
               end else if (byte_position_ff == 13'd3) begin
                  rate_index_in   = {rate_index_ff[3:1], tag_byte[7]};
                  channel_code_in = tag_byte[5:3];
               end
            end else if (is_aac && packet_kind_ff == PKT_RAW) begin
               result.load  = 1'b1;
               result.count = 3'd1;
               result.data  = {tag_byte, 48'd0};
               result.last  = (byte_position_ff == end_pos);
            end

            if (byte_position_ff >= end_pos) begin
               byte_position_in = 13'd0;
            end else begin
               byte_position_in = byte_position_ff + 13'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         sound_format_ff   <= '0;
         packet_kind_ff    <= '0;
         payload_length_ff <= '0;
         profile_code_ff   <= '0;
         rate_index_ff     <= '0;
         channel_code_ff   <= '0;
      end else begin
         byte_position_ff  <= byte_position_in;
         sound_format_ff   <= sound_format_in;
         packet_kind_ff    <= packet_kind_in;
         payload_length_ff <= payload_length_in;
         profile_code_ff   <= profile_code_in;
         rate_index_ff     <= rate_index_in;
         channel_code_ff   <= channel_code_in;
      end
   end

endmodule

### hw/rtl/flvaac_emitter.sv
// ----------------------------------------------------------------------------
// flvaac_emitter
// Output buffer: holds up to seven frame bytes and shifts them out one per
// taken response; frees itself in the cycle its final byte is taken.
// ----------------------------------------------------------------------------
module flvaac_emitter
   import flvaac_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_type      result,
   input  logic            rsp_stall,
   output logic            free,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   output emit_status_type status
);

   logic [2:0]  count_ff, count_in;
   logic [55:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        take;

   assign rsp_valid    = (count_ff != 3'd0);
   assign take         = rsp_valid && !rsp_stall;
   assign free         = (count_ff == 3'd0) || (count_ff == 3'd1 && !rsp_stall);
   assign rsp_out_byte = data_ff[55:48];
   assign rsp_out_last = last_ff && (count_ff == 3'd1);
   assign status.count = count_ff;

   always_comb begin
      count_in = count_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (take) begin
         count_in = count_ff - 3'd1;
         data_in  = {data_ff[47:0], 8'd0};
      end
      if (result.load) begin
         count_in = result.count;
         data_in  = result.data;
         last_in  = result.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule
